>>> rtl/assert_macros.svh
// shared assertion macros, clocked on clk with rst_n low masking them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sip assertion failed");

// next-cycle implication
`define SIP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sip assertion failed");

`endif

>>> rtl/sip_pkg.sv
package sip_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;
    localparam logic [3:0]  SIP_WORD_BYTES = 4'd8;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_lanes_t;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nb;
        logic        full;
        logic        fin;
    } sip_item_t;

    typedef struct packed {
        logic      valid;
        sip_item_t item;
    } sip_head_t;

    typedef struct packed {
        logic take;
        logic load;
    } sip_core_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MSG_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_DRAIN
    } sip_state_t;

    function automatic sip_lanes_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
        sip_lanes_t l;
        l.v0 = k0 ^ SIP_C0;
        l.v1 = k1 ^ SIP_C1;
        l.v2 = k0 ^ SIP_C2;
        l.v3 = k1 ^ SIP_C3;
        return l;
    endfunction

    function automatic sip_lanes_t sip_round(input sip_lanes_t a);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        sip_lanes_t  r;
        v0 = a.v0 + a.v1;
        v2 = a.v2 + a.v3;
        v1 = {a.v1[50:0], a.v1[63:51]} ^ v0;
        v3 = {a.v3[47:0], a.v3[63:48]} ^ v2;
        v0 = {v0[31:0], v0[63:32]};
        v2 = v2 + v1;
        v0 = v0 + v3;
        v1 = {v1[46:0], v1[63:47]} ^ v2;
        v3 = {v3[42:0], v3[63:43]} ^ v0;
        v2 = {v2[31:0], v2[63:32]};
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2;
        r.v3 = v3;
        return r;
    endfunction

endpackage

>>> rtl/sip_front.sv
module sip_front
    import sip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    input  logic        take,
    output sip_head_t   head
);

    sip_item_t   cls;
    sip_item_t   q_mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    // clamp byte count, drop bytes past the valid ones, flag words that end a message
    always_comb
    begin
        logic [3:0] nb;
        nb = (valid_bytes > SIP_WORD_BYTES) ? SIP_WORD_BYTES : valid_bytes;
        for (int i = 0; i < 8; i++)
        begin
            cls.word[8*i +: 8] = (4'(i) < nb) ? message_word[8*i +: 8] : 8'h00;
        end
        cls.nb   = nb;
        cls.full = (nb == SIP_WORD_BYTES);
        cls.fin  = last_word || (nb != SIP_WORD_BYTES);
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign pop        = take && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/sip_core.sv
module sip_core
    import sip_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    key_low,
    input  logic [63:0]    key_high,
    input  sip_head_t      head,
    output sip_core_stat_t stat,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [63:0]    hash_value
);

    sip_state_t  state_reg;
    sip_state_t  state_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        open_reg;
    logic        open_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [63:0] m_reg;
    logic [63:0] m_next;
    logic        last_reg;
    logic        last_next;
    sip_lanes_t  lanes_reg;
    logic [63:0] hash_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        take;
    logic        round_en;
    logic        use_key;
    logic [63:0] pre_m;
    logic [63:0] post_m;
    logic        post_ff;
    logic        out_load;
    logic        out_free;
    logic [7:0]  len_base;
    logic [7:0]  len_add;
    logic [63:0] tail_block;
    sip_lanes_t  round_in;
    sip_lanes_t  round_out;

    assign out_free   = !out_valid_reg || !out_stall;
    assign len_base   = open_reg ? len_reg : 8'd0;
    assign len_add    = len_base + {4'd0, head.item.nb};
    // partial word: top byte is already zero, length goes there
    assign tail_block = {len_add, head.item.word[55:0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = head.item.full ? ST_MSG_B : ST_FIN_B;
                end
            end
            ST_MSG_B: state_next = last_reg ? ST_FIN_A : ST_IDLE;
            ST_FIN_A: state_next = ST_FIN_B;
            ST_FIN_B: state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (cnt_reg == 2'd3 && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        take      = 1'b0;
        round_en  = 1'b0;
        use_key   = 1'b0;
        pre_m     = '0;
        post_m    = '0;
        post_ff   = 1'b0;
        out_load  = 1'b0;
        cnt_next  = cnt_reg;
        open_next = open_reg;
        len_next  = len_reg;
        m_next    = m_reg;
        last_next = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    take      = 1'b1;
                    round_en  = 1'b1;
                    use_key   = !open_reg;
                    open_next = 1'b1;
                    len_next  = len_add;
                    last_next = head.item.fin;
                    pre_m     = head.item.full ? head.item.word : tail_block;
                    m_next    = pre_m;
                end
            end
            ST_MSG_B:
            begin
                round_en = 1'b1;
                post_m   = m_reg;
            end
            ST_FIN_A:
            begin
                // full last word: length block with no tail bytes
                round_en = 1'b1;
                pre_m    = {len_reg, 56'd0};
                m_next   = pre_m;
            end
            ST_FIN_B:
            begin
                round_en = 1'b1;
                post_m   = m_reg;
                post_ff  = 1'b1;
                cnt_next = 2'd0;
            end
            ST_DRAIN:
            begin
                if (cnt_reg != 2'd3)
                begin
                    round_en = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                end
                else if (out_free)
                begin
                    round_en  = 1'b1;
                    out_load  = 1'b1;
                    open_next = 1'b0;
                end
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        round_in    = use_key ? sip_init(key_low, key_high) : lanes_reg;
        round_in.v3 = round_in.v3 ^ pre_m;
        round_out   = sip_round(round_in);
        round_out.v0 = round_out.v0 ^ post_m;
        round_out.v2 = round_out.v2 ^ (post_ff ? SIP_FIN_XOR : 64'd0);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            open_reg      <= 1'b0;
            len_reg       <= 8'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        if (round_en)
        begin
            lanes_reg <= round_out;
        end
        if (out_load)
        begin
            hash_reg <= round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
        end
    end

    assign stat.take  = take;
    assign stat.load  = out_load;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

>>> rtl/siphash_2_4_engine.sv
// keyed siphash-2-4 over a message streamed as little-endian 64-bit words
// config: write key_low (index 0) and key_high (index 1) while the block is idle;
//   cfg_ready is always high, a new key applies from the next message on
// input: message_word, valid_bytes (0..8, above 8 counts as 8), last_word; an item
//   moves when in_valid is high and in_stall low; a word with under 8 bytes ends the message
// output: one hash_value per message, moved when out_valid is high and out_stall low
// items enter a two-entry queue, the hash core takes them from its head
// the core runs one siprounds per cycle through a single round unit, except while it waits
//   for a queued item or for the result register to be taken; the states that it passes:
//   full word not ending the message: IDLE, MSG_B; final partial or empty word: IDLE,
//   FIN_B, DRAIN; full final word: IDLE, MSG_B, FIN_A, FIN_B, DRAIN
// while the result register holds an untaken hash the core waits before the last round of
//   the next hash, the queue keeps filling and in_stall rises once both entries are taken
// reset empties the queue, clears out_valid and both key registers, and the
//   next item starts a fresh message
module siphash_2_4_engine
    import sip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

`include "assert_macros.svh"

    logic [63:0]    key_low_reg;
    logic [63:0]    key_high_reg;
    sip_head_t      head;
    sip_core_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    sip_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .take         (stat.take),
        .head         (head)
    );

    sip_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .head       (head),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    `SIP_ASSERT_IMPL(a_take_has_item, stat.take, head.valid)
    `SIP_ASSERT_IMPL(a_load_only_when_free, stat.load, !(out_valid && out_stall))
    `SIP_ASSERT_NEXT(a_load_shows_result, stat.load, out_valid)

endmodule

>>> dv/tb_siphash_2_4_engine.sv
module tb_siphash_2_4_engine;
    import sip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1060;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } hash_lanes_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_index    = CFG_KEY_LOW;
    logic [63:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [63:0] message_word = '0;
    logic [3:0]  valid_bytes  = '0;
    logic        last_word    = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [63:0] hash_value;

    // predictor copy of the key registers and the running hash
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    hash_lanes_t lanes;
    logic [7:0]  msg_len = '0;
    logic        msg_open = 1'b0;

    logic [63:0] hash_expected[$];
    logic [63:0] hash_due;
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          idle_max    = 8;
    int          hold_asked  = 0;
    int          hold_taken;
    int          rx_hold;
    int          rx_wait;

    siphash_2_4_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic hash_lanes_t mix_round(input hash_lanes_t s);
        s.v0 = s.v0 + s.v1;
        s.v2 = s.v2 + s.v3;
        s.v1 = rotl(s.v1, 13) ^ s.v0;
        s.v3 = rotl(s.v3, 16) ^ s.v2;
        s.v0 = rotl(s.v0, 32);
        s.v2 = s.v2 + s.v1;
        s.v0 = s.v0 + s.v3;
        s.v1 = rotl(s.v1, 17) ^ s.v2;
        s.v3 = rotl(s.v3, 21) ^ s.v0;
        s.v2 = rotl(s.v2, 32);
        return s;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h5555_5555_5555_5555;
            default: return rand_word();
        endcase
    endfunction

    task automatic absorb(input logic [63:0] m);
        lanes.v3 = lanes.v3 ^ m;
        lanes = mix_round(mix_round(lanes));
        lanes.v0 = lanes.v0 ^ m;
    endtask

    task automatic predict_hash(input logic [63:0] word, input logic [3:0] nb_in,
                                input logic last);
        int          nb;
        logic [63:0] tail;
        nb = (nb_in > 4'd8) ? 8 : int'(nb_in);
        tail = '0;
        if (!msg_open)
        begin
            lanes.v0 = key_lo ^ SIP_C0;
            lanes.v1 = key_hi ^ SIP_C1;
            lanes.v2 = key_lo ^ SIP_C2;
            lanes.v3 = key_hi ^ SIP_C3;
            msg_len = '0;
            msg_open = 1'b1;
        end
        if (nb == 8)
        begin
            absorb(word);
            msg_len = msg_len + 8'd8;
            if (!last)
                return;
        end
        else
        begin
            tail = word & ((64'd1 << (8 * nb)) - 64'd1);
            msg_len = msg_len + 8'(nb);
        end
        absorb({msg_len, 56'd0} | tail);
        lanes.v2 = lanes.v2 ^ SIP_FIN_XOR;
        repeat (4) lanes = mix_round(lanes);
        hash_expected.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
        msg_open = 1'b0;
    endtask

    task automatic send_word(input logic [63:0] word, input logic [3:0] nb, input logic last);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= word;
        valid_bytes  <= nb;
        last_word    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_hash(word, nb, last);
        items_sent++;
    endtask

    // full words first, then one closing item
    task automatic send_message(input int full_words, input logic [3:0] tail_nb,
                                input logic tail_last);
        for (int i = 0; i < full_words; i++)
            send_word(rand_word(), ($urandom_range(0, 6) == 0) ?
                      4'($urandom_range(9, 15)) : SIP_WORD_BYTES, 1'b0);
        send_word(rand_word(), tail_nb, tail_last);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_KEY_LOW;
        cfg_data  <= k0;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_lo = k0;
        cfg_index <= CFG_KEY_HIGH;
        cfg_data  <= k1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_hi = k1;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_vectors();
        load_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        send_word('1, 4'd0, 1'b1);                         // empty message
        send_word(64'hffffffffffffff00, 4'd1, 1'b1);
        send_word(64'hff06050403020100, 4'd7, 1'b1);
        send_word(64'h0706050403020100, 4'd8, 1'b1);
        send_word(64'h0706050403020100, 4'd8, 1'b0);
        send_word(rand_word(), 4'd0, 1'b1);                // empty final word
        send_word(64'h0706050403020100, 4'd8, 1'b0);
        send_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
        send_word(rand_word(), 4'd5, 1'b0);                // short word ends message
        send_word(rand_word(), 4'd0, 1'b0);
        send_word(rand_word(), 4'd9, 1'b0);                // oversized count acts as full
        send_word('1, 4'd15, 1'b1);
        send_word('0, 4'd8, 1'b1);
        send_word('1, 4'd8, 1'b1);
        send_word(rand_word(), 4'd12, 1'b0);
        send_word(rand_word(), 4'd3, 1'b0);
    endtask

    task automatic test_key_extremes();
        load_keys('0, '0);
        send_message(0, 4'd0, 1'b1);
        send_message(1, 4'd4, 1'b1);
        load_keys('1, '1);
        send_message(0, 4'd8, 1'b1);
        send_message(2, 4'd6, 1'b1);
        load_keys(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_message(1, 4'd2, 1'b1);
        load_keys(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_message(1, 4'd7, 1'b1);
    endtask

    // lengths past 255 bytes wrap the length byte
    task automatic test_length_wrap();
        load_keys(rand_word(), rand_word());
        send_message(33, 4'd4, 1'b1);
        send_message(31, 4'd8, 1'b1);
        send_message(32, 4'd0, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_max = 0;
        hold_asked <= hold_asked + 1;
        @(posedge clk);
        for (int i = 0; i < 14; i++)
            send_message(0, 4'($urandom_range(0, 7)), 1'b1);
        wait_idle();
        idle_max = 8;
    endtask

    task automatic test_random_messages();
        int         target;
        int         phase_end;
        int         full_words;
        logic [3:0] tail_nb;
        logic       tail_last;
        target = items_sent + RANDOM_ITEMS;
        phase_end = items_sent;
        while (items_sent < target)
        begin
            if (items_sent >= phase_end)
            begin
                load_keys(pick_key(), pick_key());
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
                phase_end = items_sent + PHASE_ITEMS;
            end
            full_words = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 40)
                                                      : $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0: begin tail_nb = 4'($urandom_range(0, 7));  tail_last = 1'b0; end
                1: begin tail_nb = 4'($urandom_range(9, 15)); tail_last = 1'b1; end
                default: begin tail_nb = 4'($urandom_range(0, 8)); tail_last = 1'b1; end
            endcase
            send_message(full_words, tail_nb, tail_last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_expected.size() == 0)
            begin
                mismatches++;
                $display("%0t: hash_value expected none actual %h", $time, hash_value);
            end
            else
            begin
                hash_due = hash_expected.pop_front();
                if (hash_value !== hash_due)
                begin
                    mismatches++;
                    $display("%0t: hash_value expected %h actual %h", $time, hash_due,
                             hash_value);
                end
            end
        end
    end

    // result side: random wait after each result taken, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_taken = 0;
            rx_hold = 0;
            rx_wait = 0;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            rx_hold = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            rx_wait = $urandom_range(0, idle_max);
            out_stall <= (rx_wait != 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= (rx_wait != 0);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("siphash_2_4_engine: mismatch");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_vectors();
        test_key_extremes();
        test_length_wrap();
        test_backpressure();
        test_random_messages();
        wait_idle();
        if (mismatches == 0)
            $display("siphash_2_4_engine: match");
        else
            $display("siphash_2_4_engine: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sip_pkg.sv
rtl/sip_front.sv
rtl/sip_core.sv
rtl/siphash_2_4_engine.sv
dv/tb_siphash_2_4_engine.sv
